FILE: hw/rtl/dsmrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsmrm_pkg: shared types and constants of the mouse report merger
// Field widths, bit positions, action codes and the queue entry layout.
// ----------------------------------------------------------------------------
package dsmrm_pkg;

	localparam int BTN_W     = 5;
	localparam int MOTION_W  = 16;
	localparam int WHEEL_W   = 8;
	localparam int TIME_W    = 32;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam int S_TDATA_W = 128;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 48;
	localparam int M_TUSER_W = 2;

	localparam int QUEUE_DEPTH = 4;

	localparam int BIT_LEFT   = 0;
	localparam int BIT_MIDDLE = 2;
	localparam int BIT_B4     = 3;
	localparam int BIT_B5     = 4;

	localparam logic [WHEEL_W-1:0] LOCK_REQUEST = 8'd1;

	localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_MS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXCLUSION_MS = 2'd1;

	typedef enum logic [1:0] {
		ACT_PRESS   = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_MOVE    = 2'd2
	} action_t;

	typedef struct packed {
		logic [BTN_W-1:0]           press;
		logic [BTN_W-1:0]           release_btn;
		logic signed [MOTION_W-1:0] move_x;
		logic signed [MOTION_W-1:0] move_y;
		logic signed [WHEEL_W-1:0]  scroll;
	} poll_entry_t;

endpackage

FILE: hw/rtl/dual_source_mouse_report_merger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_source_mouse_report_merger: merge device and host mouse reports
// A poll word is taken whenever the poll queue has room; the
// front classifies it at once and the back sends its results at one word
// per cycle while the output is not stalled, so a poll yields 1 to 6 words
// (its button events plus the move word) through the single output register
// of the back. Polls with neither report produce no words. The first result
// word of a poll is registered in the queue and then in that output register.
// ----------------------------------------------------------------------------
module dual_source_mouse_report_merger #(
	parameter int QUEUE_DEPTH = dsmrm_pkg::QUEUE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dsmrm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dsmrm_pkg::CFG_W-1:0]         cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// usb_buttons, usb_dx, usb_dy, usb_wheel, serial_buttons, serial_dx,
	// serial_dy, serial_wheel, now_ms
	input  logic [dsmrm_pkg::S_TDATA_W-1:0]     s_tdata,
	// usb_valid, serial_valid
	input  logic [dsmrm_pkg::S_TUSER_W-1:0]     s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// button_mask, move_x, move_y, scroll
	output logic [dsmrm_pkg::M_TDATA_W-1:0]     m_tdata,
	// action
	output logic [dsmrm_pkg::M_TUSER_W-1:0]     m_tuser,
	output logic                                m_tlast
);

	logic                   push, full, pop, head_valid;
	dsmrm_pkg::poll_entry_t push_entry, head;

	assign cfg_ready = 1'b1;

	dsmrm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.queue_full (full),
		.push       (push),
		.push_entry (push_entry)
	);

	dsmrm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	dsmrm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

FILE: hw/rtl/dsmrm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsmrm_front: poll intake and classification
// Masks device buttons, tracks exclusion window and lockout, merges motion
// and turns each poll into press/release vectors plus one move word.
// ----------------------------------------------------------------------------
module dsmrm_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [dsmrm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dsmrm_pkg::CFG_W-1:0]         cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [dsmrm_pkg::S_TDATA_W-1:0]     s_tdata,
	input  logic [dsmrm_pkg::S_TUSER_W-1:0]     s_tuser,
	input  logic                                queue_full,
	output logic                                push,
	output dsmrm_pkg::poll_entry_t              push_entry
);

	logic [dsmrm_pkg::CFG_W-1:0]  lockout_ms_q;
	logic [dsmrm_pkg::CFG_W-1:0]  exclusion_ms_q;
	logic [dsmrm_pkg::BTN_W-1:0]  prev_dev_q;
	logic [dsmrm_pkg::BTN_W-1:0]  prev_host_q;
	logic [dsmrm_pkg::TIME_W-1:0] mid_time_q;
	logic [dsmrm_pkg::TIME_W-1:0] lock_end_q;

	logic                                dv, hv, accept;
	logic [dsmrm_pkg::BTN_W-1:0]         raw_dev, raw_host;
	logic signed [dsmrm_pkg::MOTION_W-1:0] udx, udy, sdx, sdy;
	logic signed [dsmrm_pkg::WHEEL_W-1:0]  uwheel;
	logic [dsmrm_pkg::WHEEL_W-1:0]       swheel;
	logic [dsmrm_pkg::TIME_W-1:0]        now, elapsed, lock_end_new, lock_end_next;
	logic                                dmid, window, lock_req, locked;
	logic [dsmrm_pkg::BTN_W-1:0]         dcur, dprev, hcur, hprev;
	logic [dsmrm_pkg::BTN_W-1:0]         press, rel;
	logic signed [dsmrm_pkg::MOTION_W-1:0] dx_eff, dy_eff, hx_eff, hy_eff;

	assign raw_dev  = s_tdata[4:0];
	assign udx      = s_tdata[20:5];
	assign udy      = s_tdata[36:21];
	assign uwheel   = s_tdata[44:37];
	assign raw_host = s_tdata[49:45];
	assign sdx      = s_tdata[65:50];
	assign sdy      = s_tdata[81:66];
	assign swheel   = s_tdata[89:82];
	assign now      = s_tdata[121:90];
	assign dv       = s_tuser[0];
	assign hv       = s_tuser[1];

	assign s_tready = !queue_full;
	assign accept   = s_tvalid && s_tready;
	assign push     = accept && (dv || hv);

	assign dmid         = dv && raw_dev[dsmrm_pkg::BIT_MIDDLE];
	assign elapsed      = now - mid_time_q;
	assign window       = dmid || (elapsed <= {16'd0, exclusion_ms_q});
	assign lock_req     = hv && (swheel == dsmrm_pkg::LOCK_REQUEST);
	assign lock_end_new = now + {16'd0, lockout_ms_q};
	assign lock_end_next = lock_req ? lock_end_new : lock_end_q;
	assign locked       = now <= lock_end_next;

	always_comb begin
		dprev = dv ? prev_dev_q : '0;
		dcur  = dv ? raw_dev : '0;
		dcur[dsmrm_pkg::BIT_MIDDLE] = 1'b0;
		if (dcur[dsmrm_pkg::BIT_B4] && !dprev[dsmrm_pkg::BIT_B4] && window) begin
			dcur[dsmrm_pkg::BIT_B4] = 1'b0;
		end
		if (dcur[dsmrm_pkg::BIT_B5] && !dprev[dsmrm_pkg::BIT_B5] && window) begin
			dcur[dsmrm_pkg::BIT_B5] = 1'b0;
		end
		hcur  = hv ? raw_host : '0;
		hprev = hv ? prev_host_q : '0;

		press = dcur & ~dprev;
		rel   = ~dcur & dprev;
		// left follows either source
		press[dsmrm_pkg::BIT_LEFT] = 1'b0;
		rel[dsmrm_pkg::BIT_LEFT]   = 1'b0;
		if (dcur[dsmrm_pkg::BIT_LEFT] && !hcur[dsmrm_pkg::BIT_LEFT]
				&& hprev[dsmrm_pkg::BIT_LEFT]) begin
			press[dsmrm_pkg::BIT_LEFT] = 1'b0;
		end else if (!dcur[dsmrm_pkg::BIT_LEFT] && !hcur[dsmrm_pkg::BIT_LEFT]) begin
			rel[dsmrm_pkg::BIT_LEFT] = dprev[dsmrm_pkg::BIT_LEFT]
				|| hprev[dsmrm_pkg::BIT_LEFT];
		end else begin
			press[dsmrm_pkg::BIT_LEFT] = 1'b1;
		end

		dx_eff = (dv && !locked) ? udx : '0;
		dy_eff = (dv && !locked) ? udy : '0;
		hx_eff = hv ? sdx : '0;
		hy_eff = hv ? sdy : '0;

		push_entry.press       = press;
		push_entry.release_btn = rel;
		push_entry.move_x      = dx_eff + hx_eff;
		push_entry.move_y      = dy_eff + hy_eff;
		push_entry.scroll      = dv ? uwheel : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_ms_q   <= '0;
			exclusion_ms_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				dsmrm_pkg::REG_LOCKOUT_MS:   lockout_ms_q   <= cfg_data;
				dsmrm_pkg::REG_EXCLUSION_MS: exclusion_ms_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_dev_q  <= '0;
			prev_host_q <= '0;
			mid_time_q  <= '0;
			lock_end_q  <= '0;
		end else if (accept) begin
			if (dv) begin
				prev_dev_q <= raw_dev;
			end
			if (dmid) begin
				mid_time_q <= now;
			end
			if (hv) begin
				prev_host_q <= raw_host;
			end
			if (lock_req) begin
				lock_end_q <= lock_end_new;
			end
		end
	end

endmodule

FILE: hw/rtl/dsmrm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsmrm_queue: short queue of classified polls
// Register-based first-in first-out buffer between front and back.
// ----------------------------------------------------------------------------
module dsmrm_queue #(
	parameter int DEPTH = dsmrm_pkg::QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  dsmrm_pkg::poll_entry_t push_entry,
	output logic                   full,
	input  logic                   pop,
	output logic                   head_valid,
	output dsmrm_pkg::poll_entry_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	dsmrm_pkg::poll_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full       = count_q == FULL_CNT;
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: hw/rtl/dsmrm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsmrm_back: result sequencer
// Walks the pending button events of a poll from left to b5, one word per
// cycle while the output is not stalled, and closes each poll with its move word.
// ----------------------------------------------------------------------------
module dsmrm_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            head_valid,
	input  dsmrm_pkg::poll_entry_t          head,
	output logic                            pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [dsmrm_pkg::M_TDATA_W-1:0] m_tdata,
	output logic [dsmrm_pkg::M_TUSER_W-1:0] m_tuser,
	output logic                            m_tlast
);

	logic                                  busy_q;
	logic [dsmrm_pkg::BTN_W-1:0]           pend_q, press_q;
	logic signed [dsmrm_pkg::MOTION_W-1:0] mx_q, my_q;
	logic signed [dsmrm_pkg::WHEEL_W-1:0]  sc_q;

	logic                                  out_valid_q, out_last_q;
	dsmrm_pkg::action_t                    out_act_q;
	logic [dsmrm_pkg::BTN_W-1:0]           out_mask_q;
	logic signed [dsmrm_pkg::MOTION_W-1:0] out_x_q, out_y_q;
	logic signed [dsmrm_pkg::WHEEL_W-1:0]  out_sc_q;

	logic                                  advance, have, fire;
	logic [dsmrm_pkg::BTN_W-1:0]           cur_pend, cur_press, low;
	logic signed [dsmrm_pkg::MOTION_W-1:0] cur_x, cur_y;
	logic signed [dsmrm_pkg::WHEEL_W-1:0]  cur_sc;

	assign advance   = !out_valid_q || m_tready;
	assign have      = busy_q || head_valid;
	assign fire      = advance && have;
	assign pop       = fire && !busy_q;

	assign cur_pend  = busy_q ? pend_q : (head.press | head.release_btn);
	assign cur_press = busy_q ? press_q : head.press;
	assign cur_x     = busy_q ? mx_q : head.move_x;
	assign cur_y     = busy_q ? my_q : head.move_y;
	assign cur_sc    = busy_q ? sc_q : head.scroll;
	assign low       = cur_pend & (~cur_pend + 5'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (fire) begin
			busy_q <= cur_pend != '0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pend_q  <= cur_pend & ~low;
			press_q <= cur_press;
			mx_q    <= cur_x;
			my_q    <= cur_y;
			sc_q    <= cur_sc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= have;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (cur_pend != '0) begin
				out_act_q  <= ((cur_press & low) != '0) ? dsmrm_pkg::ACT_PRESS
					: dsmrm_pkg::ACT_RELEASE;
				out_mask_q <= low;
				out_x_q    <= '0;
				out_y_q    <= '0;
				out_sc_q   <= '0;
				out_last_q <= 1'b0;
			end else begin
				out_act_q  <= dsmrm_pkg::ACT_MOVE;
				out_mask_q <= '0;
				out_x_q    <= cur_x;
				out_y_q    <= cur_y;
				out_sc_q   <= cur_sc;
				out_last_q <= 1'b1;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'd0, out_sc_q, out_y_q, out_x_q, out_mask_q};
	assign m_tuser  = out_act_q;
	assign m_tlast  = out_last_q;

endmodule
